### hdl/cht_pkg.sv
// shared constants, codes and controller/datapath handshake types
// for the coalesced hash table; no dependencies
package cht_pkg;

    localparam int TABLE_SIZE_DEF = 256;
    localparam int KEY_W          = 31;
    localparam int VAL_W          = 32;
    localparam int STAT_W         = 2;
    localparam int SLOT_W         = 8;

    // result status codes
    localparam logic [STAT_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_FOUND     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    // table write selects
    localparam int WSEL_W = 3;
    localparam logic [WSEL_W-1:0] W_NONE     = 3'd0;
    localparam logic [WSEL_W-1:0] W_CLR      = 3'd1;
    localparam logic [WSEL_W-1:0] W_NEW_POS  = 3'd2;
    localparam logic [WSEL_W-1:0] W_FR_PRI   = 3'd3;
    localparam logic [WSEL_W-1:0] W_FR_SEC   = 3'd4;
    localparam logic [WSEL_W-1:0] W_POS_LINK = 3'd5;
    localparam logic [WSEL_W-1:0] W_RELINK   = 3'd6;

    typedef struct packed {
        logic              load;       // capture word, start home hash
        logic              occ_hash;   // start hash of saved occupant key
        logic              take_home;  // latch home slot, read it
        logic              save_occ;   // keep occupant, start free scan
        logic              scan_next;  // read next scan slot
        logic              take_free;  // latch free slot
        logic              start_walk; // read head of occupant chain
        logic              follow;     // read next slot of chain
        logic [WSEL_W-1:0] wsel;
        logic              set_res;
        logic [STAT_W-1:0] res_status;
        logic              res_hit;
        logic              push;
    } t_cmd;

    typedef struct packed {
        logic mod_busy;
        logic is_lookup;
        logic rd_used;
        logic key_eq;
        logic has_next;
        logic next_eq_pos;
        logic next_ok;
        logic steps_last;
        logic scan_last;
        logic home_eq_pos;
        logic clr_last;
        logic out_free;
    } t_stat;

endpackage

### hdl/cht_in_if.sv
// request channel: operation, key and value words
// depends on cht_pkg
interface cht_in_if;
    import cht_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    func;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, func, key, value, input ready);
    modport sink   (input valid, func, key, value, output ready);
endinterface

### hdl/cht_out_if.sv
// response channel: status and slot words
// depends on cht_pkg
interface cht_out_if;
    import cht_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;

    modport source (output valid, status, slot, input ready);
    modport sink   (input valid, status, slot, output ready);
endinterface

### hdl/cht_ram.sv
// simple dual-port table memory, one write and one registered read per cycle
// no dependencies
module cht_ram #(
    parameter int   DEPTH = 256,
    parameter int   WIDTH = 8,
    localparam int  AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/cht_mod.sv
// key modulo table size by reciprocal multiplication in a pipeline
// depends on cht_pkg
module cht_mod #(
    parameter int  TABLE_SIZE = cht_pkg::TABLE_SIZE_DEF,
    localparam int IDX_W      = $clog2(TABLE_SIZE)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [cht_pkg::KEY_W-1:0] i_dividend,
    output logic                    o_busy,
    output logic [IDX_W-1:0]        o_rem
);
    import cht_pkg::*;

    localparam int STAGES = 4;
    localparam int CNT_W  = $clog2(STAGES + 1);
    localparam int PROD_W = KEY_W + 32;
    // floor(2^32 / size): the quotient estimate is exact or one short
    localparam logic [31:0]      RECIP = 32'((64'd1 << 32) / TABLE_SIZE);
    localparam logic [KEY_W-1:0] TS_K  = KEY_W'(TABLE_SIZE);

    logic [KEY_W-1:0]  r_x;
    logic [PROD_W-1:0] r_prod;
    logic [KEY_W-1:0]  r_qd;
    logic [KEY_W-1:0]  r_diff;
    logic [IDX_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(STAGES);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // estimate quotient, multiply back, subtract, then one correction step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_dividend;
        end
        r_prod <= PROD_W'(r_x) * PROD_W'(RECIP);
        r_qd   <= r_prod[PROD_W-1:32] * TS_K;
        r_diff <= r_x - r_qd;
        r_rem  <= IDX_W'((r_diff >= TS_K) ? (r_diff - TS_K) : r_diff);
    end

    assign o_busy = (r_cnt != '0);
    assign o_rem  = r_rem;

endmodule

### hdl/cht_datapath.sv
// table datapath: item registers, modulo unit, table memory, pointers
// and response register; depends on cht_pkg, cht_mod, cht_ram
module cht_datapath #(
    parameter int  TABLE_SIZE = cht_pkg::TABLE_SIZE_DEF,
    localparam int IDX_W      = $clog2(TABLE_SIZE)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cht_pkg::t_cmd              i_cmd,
    output cht_pkg::t_stat             o_stat,
    input  logic                       i_func,
    input  logic [cht_pkg::KEY_W-1:0]  i_key,
    input  logic [cht_pkg::VAL_W-1:0]  i_value,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [cht_pkg::STAT_W-1:0] o_out_status,
    output logic [cht_pkg::SLOT_W-1:0] o_out_slot
);
    import cht_pkg::*;

    typedef struct packed {
        logic              used;
        logic              has_next;
        logic [IDX_W-1:0]  nxt;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } t_entry;

    localparam int ENT_W = $bits(t_entry);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam logic [IDX_W:0]   TS_C     = (IDX_W+1)'(TABLE_SIZE);

    logic              r_func;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_value;
    logic [IDX_W-1:0]  r_pos, r_cur, r_fr, r_scan, r_base, r_steps, r_clr;
    t_entry            r_occ;
    logic [STAT_W-1:0] r_res_status;
    logic [IDX_W-1:0]  r_res_slot;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [SLOT_W-1:0] r_out_slot;

    logic              w_mod_start, w_mod_busy;
    logic [KEY_W-1:0]  w_mod_arg;
    logic [IDX_W-1:0]  w_home;
    logic              w_we;
    logic [IDX_W-1:0]  w_waddr, w_raddr;
    t_entry            w_wdata, rd;
    logic [ENT_W-1:0]  w_rdata;

    assign w_mod_start = i_cmd.load | i_cmd.occ_hash;
    assign w_mod_arg   = i_cmd.load ? i_key : r_occ.key;

    cht_mod #(.TABLE_SIZE(TABLE_SIZE)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_mod_arg),
        .o_busy     (w_mod_busy),
        .o_rem      (w_home)
    );

    // read address follows whichever walk is running
    always_comb begin
        w_raddr = r_cur;
        if (i_cmd.take_home || i_cmd.start_walk) begin
            w_raddr = w_home;
        end else if (i_cmd.save_occ) begin
            w_raddr = r_base;
        end else if (i_cmd.scan_next) begin
            w_raddr = r_scan + 1'b1;
        end else if (i_cmd.follow) begin
            w_raddr = rd.nxt;
        end
    end

    always_comb begin
        w_we    = 1'b1;
        w_waddr = r_pos;
        w_wdata = '{used: 1'b1, has_next: 1'b0, nxt: '0, key: r_key, value: r_value};
        case (i_cmd.wsel)
            W_CLR: begin
                w_waddr = r_clr;
                w_wdata = '0;
            end
            W_NEW_POS: begin
                w_waddr = r_pos;
            end
            W_FR_PRI: begin
                w_waddr = r_fr;
                w_wdata = '{used: 1'b1, has_next: r_occ.has_next, nxt: r_occ.nxt,
                            key: r_key, value: r_value};
            end
            W_FR_SEC: begin
                w_waddr = r_fr;
                w_wdata = r_occ;
                w_wdata.used = 1'b1;
            end
            W_POS_LINK: begin
                w_waddr = r_pos;
                w_wdata = r_occ;
                w_wdata.has_next = 1'b1;
                w_wdata.nxt = r_fr;
            end
            W_RELINK: begin
                w_waddr = r_cur;
                w_wdata = rd;
                w_wdata.nxt = r_fr;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    cht_ram #(.DEPTH(TABLE_SIZE), .WIDTH(ENT_W)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign rd = t_entry'(w_rdata);

    // control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.wsel == W_CLR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.take_free) begin
                r_base <= r_scan;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (i_cmd.take_home) begin
            r_pos   <= w_home;
            r_cur   <= w_home;
            r_steps <= '0;
        end
        if (i_cmd.start_walk) begin
            r_cur   <= w_home;
            r_steps <= '0;
        end
        if (i_cmd.follow) begin
            r_cur   <= rd.nxt;
            r_steps <= r_steps + 1'b1;
        end
        if (i_cmd.save_occ) begin
            r_occ  <= rd;
            r_scan <= r_base;
        end
        if (i_cmd.scan_next) begin
            r_scan <= r_scan + 1'b1;
        end
        if (i_cmd.take_free) begin
            r_fr <= r_scan;
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_status;
            r_res_slot   <= i_cmd.res_hit ? r_cur : '0;
        end
        if (i_cmd.push) begin
            r_out_status <= r_res_status;
            r_out_slot   <= SLOT_W'(r_res_slot);
        end
    end

    always_comb begin
        o_stat.mod_busy    = w_mod_busy;
        o_stat.is_lookup   = r_func;
        o_stat.rd_used     = rd.used;
        o_stat.key_eq      = (rd.key == r_key);
        o_stat.has_next    = rd.has_next;
        o_stat.next_eq_pos = (rd.nxt == r_pos);
        o_stat.next_ok     = ({1'b0, rd.nxt} < TS_C);
        o_stat.steps_last  = (r_steps == LAST_IDX);
        o_stat.scan_last   = (r_scan == LAST_IDX);
        o_stat.home_eq_pos = (w_home == r_pos);
        o_stat.clr_last    = (r_clr == LAST_IDX);
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_slot   = r_out_slot;

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (!r_out_valid || i_out_ready))
        else $error("response overwritten before it was taken");

    a_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_free |-> !rd.used)
        else $error("occupied slot taken as free");

    a_relink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wsel == W_RELINK) |-> (rd.nxt == r_pos))
        else $error("relink of a slot not pointing at the home slot");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_FOUND)) |-> (r_out_slot == '0))
        else $error("nonzero slot on a miss or insert");

endmodule

### hdl/cht_ctrl.sv
// sequencing state machine for clear, insert and lookup
// depends on cht_pkg
module cht_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cht_pkg::t_stat i_stat,
    output logic           o_ready,
    output cht_pkg::t_cmd  o_cmd
);
    import cht_pkg::*;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_HASH    = 4'd2;
    localparam logic [3:0] S_HOME    = 4'd3;
    localparam logic [3:0] S_INS_CHK = 4'd4;
    localparam logic [3:0] S_SCAN    = 4'd5;
    localparam logic [3:0] S_OHASH   = 4'd6;
    localparam logic [3:0] S_CONF    = 4'd7;
    localparam logic [3:0] S_PRI2    = 4'd8;
    localparam logic [3:0] S_WALK    = 4'd9;
    localparam logic [3:0] S_SEC_END = 4'd10;
    localparam logic [3:0] S_LK_CHK  = 4'd11;
    localparam logic [3:0] S_OUT     = 4'd12;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.wsel = W_CLR;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (!i_stat.mod_busy) begin
                    n_state = S_HOME;
                end
            end
            S_HOME: begin
                o_cmd.take_home = 1'b1;
                n_state = i_stat.is_lookup ? S_LK_CHK : S_INS_CHK;
            end
            S_INS_CHK: begin
                if (!i_stat.rd_used) begin
                    o_cmd.wsel       = W_NEW_POS;
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_INSERTED;
                    n_state = S_OUT;
                end else begin
                    o_cmd.save_occ = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_stat.rd_used) begin
                    o_cmd.take_free = 1'b1;
                    o_cmd.occ_hash  = 1'b1;
                    n_state = S_OHASH;
                end else if (i_stat.scan_last) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_FULL;
                    n_state = S_OUT;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_OHASH: begin
                if (!i_stat.mod_busy) begin
                    n_state = S_CONF;
                end
            end
            S_CONF: begin
                if (i_stat.home_eq_pos) begin
                    o_cmd.wsel = W_FR_PRI;
                    n_state = S_PRI2;
                end else begin
                    o_cmd.wsel       = W_FR_SEC;
                    o_cmd.start_walk = 1'b1;
                    n_state = S_WALK;
                end
            end
            S_PRI2: begin
                o_cmd.wsel       = W_POS_LINK;
                o_cmd.set_res    = 1'b1;
                o_cmd.res_status = ST_INSERTED;
                n_state = S_OUT;
            end
            S_WALK: begin
                if (!i_stat.has_next) begin
                    n_state = S_SEC_END;
                end else if (i_stat.next_eq_pos) begin
                    o_cmd.wsel = W_RELINK;
                    n_state = S_SEC_END;
                end else if (!i_stat.next_ok || i_stat.steps_last) begin
                    n_state = S_SEC_END;
                end else begin
                    o_cmd.follow = 1'b1;
                end
            end
            S_SEC_END: begin
                o_cmd.wsel       = W_NEW_POS;
                o_cmd.set_res    = 1'b1;
                o_cmd.res_status = ST_INSERTED;
                n_state = S_OUT;
            end
            S_LK_CHK: begin
                if (!i_stat.rd_used) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_NOT_FOUND;
                    n_state = S_OUT;
                end else if (i_stat.key_eq) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_FOUND;
                    o_cmd.res_hit    = 1'b1;
                    n_state = S_OUT;
                end else if (!i_stat.has_next || !i_stat.next_ok || i_stat.steps_last) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_NOT_FOUND;
                    n_state = S_OUT;
                end else begin
                    o_cmd.follow = 1'b1;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/coalesced_hash_table_core.sv
// time from accepting edge to valid response: a lookup grows with links followed,
// a conflict insert with slots scanned and, for a secondary conflict, links walked;
// a full table with slots scanned; each hash waits on the modulo unit
// one word at a time: the next is taken in the cycle after the response is pushed
// reset: synchronous active low, then a clearing pass over every slot of the
// table memory before the first request word is taken
module coalesced_hash_table_core #(
    parameter int TABLE_SIZE = cht_pkg::TABLE_SIZE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cht_in_if.sink    i_req,
    cht_out_if.source o_rsp
);
    import cht_pkg::*;

    // command and status between sequencer and datapath
    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer: owns the only state machine; it waits out the modulo unit,
    // steps the free-slot scan and the chain walks one slot per cycle, and
    // holds the finished response until the output register is free
    cht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .i_stat  (w_stat),
        .o_ready (i_req.ready),
        .o_cmd   (w_cmd)
    );

    // datapath: request registers, shared modulo unit for the key and the
    // displaced occupant's key, table memory with registered read, the
    // free-scan base pointer (slots are never freed so it only moves up) and
    // the response register that decouples the two channels
    cht_datapath #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_func       (i_req.func),
        .i_key        (i_req.key),
        .i_value      (i_req.value),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_out_status (o_rsp.status),
        .o_out_slot   (o_rsp.slot)
    );

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// testbench for coalesced_hash_table_core: insert and lookup words checked against
// a behavioral copy of the table; depends on cht_pkg, cht_in_if and cht_out_if
module tb_top;
    import cht_pkg::*;

    localparam int TBL_N       = TABLE_SIZE_DEF;
    localparam bit OP_INSERT   = 1'b0;
    localparam bit OP_LOOKUP   = 1'b1;
    // worst word: a full free-slot scan plus a full chain walk
    localparam int DRAIN_WAIT  = 600;
    localparam int STALL_LIMIT = 10000;
    localparam int PRINT_MAX   = 100;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
    } t_rsp_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cht_in_if  req_if ();
    cht_out_if rsp_if ();

    coalesced_hash_table_core #(
        .TABLE_SIZE(TBL_N)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    always #10 i_clk = ~i_clk;

    // behavioral table, empty after reset
    bit               ht_busy    [TBL_N];
    logic [KEY_W-1:0] ht_key     [TBL_N];
    logic [VAL_W-1:0] ht_val     [TBL_N];
    bit               ht_chained [TBL_N];
    int unsigned      ht_link    [TBL_N];

    t_rsp_word        rsp_expected [$];
    logic [KEY_W-1:0] stored_keys  [$];
    logic [STAT_W-1:0] last_status;

    int snd_idle_pct  = 0;
    int rcv_idle_pct  = 0;
    int rsp_hold_left = 0;
    int err_count     = 0;
    int rsp_count     = 0;
    int stall_cycles  = 0;

    function automatic void ht_fill(int unsigned s, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                                    bit chained, int unsigned link);
        ht_busy[s]    = 1'b1;
        ht_key[s]     = k;
        ht_val[s]     = v;
        ht_chained[s] = chained;
        ht_link[s]    = link;
    endfunction

    // applies one operation to the behavioral table and returns the response word
    function automatic t_rsp_word predict_table_op(bit func, logic [KEY_W-1:0] key,
                                                   logic [VAL_W-1:0] value);
        t_rsp_word   r;
        int unsigned home;
        int unsigned free_slot;
        int unsigned occ_home;
        int unsigned walk;
        bit          found_free;
        r.status = ST_NOT_FOUND;
        r.slot   = '0;
        home     = key % TBL_N;
        if (func == OP_LOOKUP) begin
            // walk the chain from home, bounded to the table size
            walk = home;
            for (int steps = 0; steps < TBL_N; steps++) begin
                if (!ht_busy[walk])
                    break;
                if (ht_key[walk] == key) begin
                    r.status = ST_FOUND;
                    r.slot   = walk[SLOT_W-1:0];
                    return r;
                end
                if (!ht_chained[walk])
                    break;
                walk = ht_link[walk];
                if (walk >= TBL_N)
                    break;
            end
            return r;
        end
        r.status = ST_INSERTED;
        if (!ht_busy[home]) begin
            ht_fill(home, key, value, 1'b0, 0);
            return r;
        end
        found_free = 1'b0;
        free_slot  = 0;
        for (int s = 0; s < TBL_N; s++) begin
            if (!ht_busy[s]) begin
                free_slot  = s;
                found_free = 1'b1;
                break;
            end
        end
        if (!found_free) begin
            r.status = ST_FULL;
            return r;
        end
        occ_home = ht_key[home] % TBL_N;
        if (occ_home != home) begin
            // occupant belongs to another chain: move it out, repoint its predecessor
            ht_fill(free_slot, ht_key[home], ht_val[home], ht_chained[home], ht_link[home]);
            walk = occ_home;
            for (int steps = 0; steps < TBL_N; steps++) begin
                if (!ht_chained[walk])
                    break;
                if (ht_link[walk] == home) begin
                    ht_link[walk] = free_slot;
                    break;
                end
                walk = ht_link[walk];
                if (walk >= TBL_N)
                    break;
            end
            ht_fill(home, key, value, 1'b0, 0);
        end else begin
            // same chain: new key goes right after the home slot
            ht_fill(free_slot, key, value, ht_chained[home], ht_link[home]);
            ht_chained[home] = 1'b1;
            ht_link[home]    = free_slot;
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        err_count++;
        if (err_count <= PRINT_MAX)
            $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    // one request word; idles at random first, prediction happens at acceptance
    task automatic send_word(bit func, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
        t_rsp_word w;
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.func  <= func;
        req_if.key   <= key;
        req_if.value <= value;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        w = predict_table_op(func, key, value);
        rsp_expected.push_back(w);
        last_status = w.status;
        if (func == OP_INSERT && w.status == ST_INSERTED)
            stored_keys.push_back(key);
    endtask

    // sender pause: hold valid low until every response is back
    task automatic wait_responses_drained();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (rsp_expected.size() != 0)
            @(posedge i_clk);
    endtask

    // keys crowd the low homes, where overflow slots land, to force relocations
    function automatic logic [KEY_W-1:0] pick_key(bit func);
        logic [KEY_W-1:0] k;
        int unsigned      sel;
        sel = $urandom_range(99);
        k   = KEY_W'($urandom);
        if (stored_keys.size() != 0) begin
            if ((func == OP_LOOKUP && sel < 55) || (func == OP_INSERT && sel < 10))
                return stored_keys[$urandom_range(stored_keys.size() - 1)];
        end
        if (sel >= 20)
            k[SLOT_W-1:0] = SLOT_W'($urandom_range(31));
        return k;
    endfunction

    task automatic run_mix(int n_words, int insert_pct);
        bit func;
        for (int n = 0; n < n_words; n++) begin
            func = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_LOOKUP;
            send_word(func, pick_key(func), $urandom);
        end
    endtask

    // empty-table miss, extremes, primary and secondary conflicts, duplicates
    task automatic test_directed();
        snd_idle_pct = 35;
        rcv_idle_pct = 73;
        send_word(OP_LOOKUP, 31'd0, 32'd0);
        send_word(OP_INSERT, 31'd0, 32'h8000_0000);
        send_word(OP_INSERT, 31'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(OP_LOOKUP, 31'd0, 32'hFFFF_FFFF);
        send_word(OP_LOOKUP, 31'h7FFF_FFFF, 32'd0);
        send_word(OP_INSERT, 31'd256, 32'd0);             // same home as key 0
        send_word(OP_LOOKUP, 31'd256, 32'd0);
        send_word(OP_INSERT, 31'd1, 32'h1234_5678);       // home held by a foreign key
        send_word(OP_LOOKUP, 31'd256, 32'd0);
        send_word(OP_LOOKUP, 31'd1, 32'd0);
        send_word(OP_INSERT, 31'd0, 32'hFFFF_FFFF);       // duplicate key
        send_word(OP_LOOKUP, 31'd0, 32'd0);
        send_word(OP_INSERT, 31'd512, 32'hA5A5_A5A5);
        send_word(OP_INSERT, 31'd4, 32'h5A5A_5A5A);       // predecessor is the chain head
        send_word(OP_LOOKUP, 31'd512, 32'd0);
        send_word(OP_LOOKUP, 31'd4, 32'd0);
        send_word(OP_LOOKUP, 31'd768, 32'd0);             // miss after a full chain walk
        send_word(OP_INSERT, 31'd3, 32'd7);               // predecessor mid chain
        send_word(OP_LOOKUP, 31'd256, 32'd0);
        send_word(OP_LOOKUP, 31'd3, 32'd0);
        send_word(OP_INSERT, 31'd511, 32'd9);             // collides at the top slot
        send_word(OP_LOOKUP, 31'd511, 32'd0);
        send_word(OP_LOOKUP, 31'h7FFF_FF00, 32'd0);
        wait_responses_drained();
    endtask

    task automatic test_mix_slow_sink();
        snd_idle_pct = 35;
        rcv_idle_pct = 73;
        run_mix(600, 20);
        wait_responses_drained();
    endtask

    task automatic test_mix_slow_source();
        snd_idle_pct = 73;
        rcv_idle_pct = 35;
        run_mix(600, 15);
        wait_responses_drained();
    endtask

    // response side held off while words keep coming, so the input stalls
    task automatic test_output_backpressure();
        snd_idle_pct  = 0;
        rcv_idle_pct  = 0;
        rsp_hold_left = 300;
        run_mix(24, 50);
        wait_responses_drained();
    endtask

    task automatic test_mix_full_rate();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_mix(660, 30);
        wait_responses_drained();
    endtask

    // fill whatever is left, then inserts into a full table and lookups on it
    task automatic test_table_full();
        int n;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        n = 0;
        do begin
            send_word(OP_INSERT, pick_key(OP_INSERT), $urandom);
            n++;
        end while (last_status != ST_FULL && n < 2 * TBL_N);
        run_mix(10, 100);
        run_mix(30, 0);
        wait_responses_drained();
    endtask

    // response side: random idling, or a counted hold-off when one is requested
    always @(negedge i_clk) begin
        if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // each response word against the oldest prediction
    always @(posedge i_clk) begin
        t_rsp_word want;
        if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            rsp_count++;
            if (rsp_expected.size() == 0) begin
                report_mismatch($sformatf("response %0d with nothing pending", rsp_count));
            end else begin
                want = rsp_expected.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch($sformatf("response %0d status %0d, want %0d",
                                              rsp_count, rsp_if.status, want.status));
                if (rsp_if.slot !== want.slot)
                    report_mismatch($sformatf("response %0d slot %0d, want %0d",
                                              rsp_count, rsp_if.slot, want.slot));
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.func  = OP_INSERT;
        req_if.key   = '0;
        req_if.value = '0;
        rsp_if.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_mix_slow_sink();
        test_mix_slow_source();
        test_output_backpressure();
        test_mix_full_rate();
        test_table_full();

        // any late or extra response still shows up in this window
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0 && rsp_expected.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
hdl/cht_pkg.sv
hdl/cht_in_if.sv
hdl/cht_out_if.sv
hdl/cht_ram.sv
hdl/cht_mod.sv
hdl/cht_datapath.sv
hdl/cht_ctrl.sv
hdl/coalesced_hash_table_core.sv
dv/tb_top.sv
